>>> sv/bthin_pkg.sv
// ============================================================================
// bthin_pkg
// Shared types and constants of the binary image thinning block.
// ============================================================================
`default_nettype none

package bthin_pkg;

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_START   = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [8:0]  GEOM_RESET = 9'd256;
    localparam logic [15:0] PASS_LIMIT = 16'd32768;
    localparam logic [7:0]  PIX_FG     = 8'd255;
    localparam logic [7:0]  PIX_BG     = 8'd0;

    typedef struct packed {
        logic take;
        logic rd_load;
        logic run_init;
        logic pass_init;
        logic mark_step;
        logic sw_rd;
        logic sw_wr;
        logic phase_set;
        logic pass_end;
        logic done_load;
    } bthin_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic no_interior;
        logic mark_last;
        logic pix_last;
        logic changed;
        logic phase;
    } bthin_sts_t;

endpackage

`default_nettype wire

>>> sv/bthin_if.sv
// ============================================================================
// bthin_if
// Request and result channels of the binary image thinning block.
// ============================================================================
`default_nettype none

interface bthin_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] pixel_in;

    modport source (output valid, req_type, row, col, pixel_in, input ready);
    modport sink (input valid, req_type, row, col, pixel_in, output ready);
endinterface

interface bthin_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_out;
    logic [15:0] pass_count;

    modport source (output valid, pixel_out, pass_count, input ready);
    modport sink (input valid, pixel_out, pass_count, output ready);
endinterface

`default_nettype wire

>>> sv/bthin_ctrl.sv
// ============================================================================
// bthin_ctrl
// Sequencer that accepts words and steps the datapath through the passes.
// ============================================================================
`default_nettype none

module bthin_ctrl
    import bthin_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_req_type,
    output logic            in_ready,
    input  wire logic       out_ready,
    input  wire bthin_sts_t sts,
    output bthin_cmd_t      cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RDWAIT = 8'b0000_0010,
        S_PASS   = 8'b0000_0100,
        S_MARK   = 8'b0000_1000,
        S_SWRD   = 8'b0001_0000,
        S_SWWR   = 8'b0010_0000,
        S_PEND   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = !sts.out_busy || out_ready;
                if (in_valid && in_ready)
                begin
                    cmd.take = 1'b1;
                    if (in_req_type == REQ_READ)
                    begin
                        state_next = S_RDWAIT;
                    end
                    else if (in_req_type == REQ_START)
                    begin
                        cmd.run_init = 1'b1;
                        state_next   = S_PASS;
                    end
                end
            end
            S_RDWAIT:
            begin
                cmd.rd_load = 1'b1;
                state_next  = S_IDLE;
            end
            S_PASS:
            begin
                cmd.pass_init = 1'b1;
                state_next    = sts.no_interior ? S_PEND : S_MARK;
            end
            S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (sts.mark_last)
                begin
                    state_next = S_SWRD;
                end
            end
            S_SWRD:
            begin
                cmd.sw_rd  = 1'b1;
                state_next = S_SWWR;
            end
            S_SWWR:
            begin
                cmd.sw_wr = 1'b1;
                if (!sts.pix_last)
                begin
                    state_next = S_SWRD;
                end
                else if (!sts.phase)
                begin
                    cmd.phase_set = 1'b1;
                    state_next    = S_MARK;
                end
                else
                begin
                    state_next = S_PEND;
                end
            end
            S_PEND:
            begin
                cmd.pass_end = 1'b1;
                state_next   = sts.changed ? S_PASS : S_DONE;
            end
            S_DONE:
            begin
                cmd.done_load = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/bthin_dp.sv
// ============================================================================
// bthin_dp
// Image and mark stores, scan counters, pixel rule and result register.
// ============================================================================
`default_nettype none

module bthin_dp
    import bthin_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  row,
    input  wire logic [7:0]  col,
    input  wire logic [7:0]  pixel_in,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic [7:0]       pixel_out,
    output logic [15:0]      pass_count,
    input  wire bthin_cmd_t  cmd,
    output bthin_sts_t       sts
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAX_ROWS << CW;

    logic img_mem [DEPTH];
    logic mark_mem [DEPTH];

    logic [8:0]    rows_reg;
    logic [8:0]    cols_reg;
    logic [RW-1:0] r_reg;
    logic [CW-1:0] c_reg;
    logic [RW-1:0] lim_r_reg;
    logic [CW-1:0] lim_c_reg;
    logic          noint_reg;
    logic [3:0]    nb_reg;
    logic [6:0]    nbr_reg;
    logic          phase_reg;
    logic          changed_reg;
    logic [15:0]   passes_reg;
    logic          rd_ok_reg;
    logic          img_rd;
    logic          mark_rd;
    logic          out_valid_reg;
    logic [7:0]    pix_out_reg;
    logic [15:0]   cnt_out_reg;

    logic [15:0]   nr;
    logic [15:0]   nc;
    logic          addr_ok;
    logic [AW-1:0] req_addr;
    logic [AW-1:0] pix_addr;
    logic [AW-1:0] nb_addr;
    logic [AW-1:0] rd_addr;
    logic [RW-1:0] nb_r;
    logic [CW-1:0] nb_c;
    logic          pix_last;
    logic [7:0]    nwin;
    logic          mark;
    logic          img_we;
    logic [AW-1:0] img_waddr;
    logic          img_wdata;

    function automatic logic mark_rule(input logic [7:0] n, input logic ph);
        logic [3:0] cnt;
        logic [3:0] trans;
        logic       m1;
        logic       m2;
        cnt   = '0;
        trans = '0;
        for (int k = 0; k < 8; k++)
        begin
            cnt = cnt + 4'(n[k]);
            trans = trans + 4'(!n[k] && n[(k + 1) % 8]);
        end
        if (!ph)
        begin
            m1 = n[0] & n[2] & n[4];
            m2 = n[2] & n[4] & n[6];
        end
        else
        begin
            m1 = n[0] & n[2] & n[6];
            m2 = n[0] & n[4] & n[6];
        end
        return (trans == 4'd1) && (cnt >= 4'd2) && (cnt <= 4'd6) && !m1 && !m2;
    endfunction

    assign nr = ({7'd0, rows_reg} > 16'(MAX_ROWS)) ? 16'(MAX_ROWS) : {7'd0, rows_reg};
    assign nc = ({7'd0, cols_reg} > 16'(MAX_COLS)) ? 16'(MAX_COLS) : {7'd0, cols_reg};

    assign addr_ok  = ({8'd0, row} < 16'(MAX_ROWS)) && ({8'd0, col} < 16'(MAX_COLS));
    assign req_addr = {RW'(row), CW'(col)};
    assign pix_addr = {r_reg, c_reg};
    assign pix_last = (r_reg == lim_r_reg) && (c_reg == lim_c_reg);

    always_comb
    begin
        nb_r = r_reg;
        nb_c = c_reg;
        case (nb_reg[2:0])
            3'd0: nb_r = r_reg - 1'b1;
            3'd1:
            begin
                nb_r = r_reg - 1'b1;
                nb_c = c_reg + 1'b1;
            end
            3'd2: nb_c = c_reg + 1'b1;
            3'd3:
            begin
                nb_r = r_reg + 1'b1;
                nb_c = c_reg + 1'b1;
            end
            3'd4: nb_r = r_reg + 1'b1;
            3'd5:
            begin
                nb_r = r_reg + 1'b1;
                nb_c = c_reg - 1'b1;
            end
            3'd6: nb_c = c_reg - 1'b1;
            3'd7:
            begin
                nb_r = r_reg - 1'b1;
                nb_c = c_reg - 1'b1;
            end
            default: nb_r = r_reg;
        endcase
    end

    assign nb_addr = {nb_r, nb_c};
    assign rd_addr = cmd.take ? req_addr : (cmd.mark_step ? nb_addr : pix_addr);
    assign nwin    = {img_rd, nbr_reg};
    assign mark    = mark_rule(nwin, phase_reg);

    assign img_we    = (cmd.take && req_type == REQ_WRITE && addr_ok)
                       || (cmd.sw_wr && img_rd && mark_rd);
    assign img_waddr = cmd.take ? req_addr : pix_addr;
    assign img_wdata = cmd.take ? pixel_in[7] : 1'b0;

    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            img_mem[img_waddr] <= img_wdata;
        end
        img_rd <= img_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark_step && nb_reg[3])
        begin
            mark_mem[pix_addr] <= mark;
        end
        if (cmd.sw_rd)
        begin
            mark_rd <= mark_mem[pix_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark_step && !nb_reg[3] && nb_reg != 4'd0)
        begin
            nbr_reg[3'(nb_reg - 4'd1)] <= img_rd;
        end
        if (cmd.take)
        begin
            rd_ok_reg <= addr_ok;
        end
        if (cmd.run_init)
        begin
            lim_r_reg <= RW'(nr - 16'd2);
            lim_c_reg <= CW'(nc - 16'd2);
            noint_reg <= (nr < 16'd3) || (nc < 16'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= GEOM_RESET;
            cols_reg      <= GEOM_RESET;
            r_reg         <= '0;
            c_reg         <= '0;
            nb_reg        <= '0;
            phase_reg     <= 1'b0;
            changed_reg   <= 1'b0;
            passes_reg    <= '0;
            out_valid_reg <= 1'b0;
            pix_out_reg   <= '0;
            cnt_out_reg   <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_ROWS)
            begin
                rows_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_COLS)
            begin
                cols_reg <= cfg_wdata;
            end
            if (cmd.run_init)
            begin
                passes_reg <= '0;
            end
            if (cmd.pass_init)
            begin
                r_reg       <= RW'(1);
                c_reg       <= CW'(1);
                nb_reg      <= '0;
                phase_reg   <= 1'b0;
                changed_reg <= 1'b0;
            end
            if (cmd.phase_set)
            begin
                phase_reg <= 1'b1;
            end
            if (cmd.mark_step)
            begin
                nb_reg <= nb_reg[3] ? 4'd0 : nb_reg + 4'd1;
            end
            if ((cmd.mark_step && nb_reg[3]) || cmd.sw_wr)
            begin
                if (pix_last)
                begin
                    r_reg <= RW'(1);
                    c_reg <= CW'(1);
                end
                else if (c_reg == lim_c_reg)
                begin
                    r_reg <= r_reg + 1'b1;
                    c_reg <= CW'(1);
                end
                else
                begin
                    c_reg <= c_reg + 1'b1;
                end
            end
            if (cmd.sw_wr && img_rd && mark_rd)
            begin
                changed_reg <= 1'b1;
            end
            if (cmd.pass_end && passes_reg < PASS_LIMIT)
            begin
                passes_reg <= passes_reg + 16'd1;
            end
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.take && !(req_type inside {REQ_READ, REQ_START}))
            begin
                out_valid_reg <= 1'b1;
                pix_out_reg   <= PIX_BG;
                cnt_out_reg   <= passes_reg;
            end
            if (cmd.rd_load)
            begin
                out_valid_reg <= 1'b1;
                pix_out_reg   <= (rd_ok_reg && img_rd) ? PIX_FG : PIX_BG;
                cnt_out_reg   <= passes_reg;
            end
            if (cmd.done_load)
            begin
                out_valid_reg <= 1'b1;
                pix_out_reg   <= PIX_BG;
                cnt_out_reg   <= passes_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pix_out_reg;
    assign pass_count = cnt_out_reg;

    always_comb
    begin
        sts             = '0;
        sts.out_busy    = out_valid_reg;
        sts.no_interior = noint_reg;
        sts.mark_last   = nb_reg[3] && pix_last;
        sts.pix_last    = pix_last;
        sts.changed     = changed_reg;
        sts.phase       = phase_reg;
    end

endmodule

`default_nettype wire

>>> sv/binary_image_thinning.sv
// ============================================================================
// binary_image_thinning
// Two-subpass thinning of a one-bit image held in an on-chip store.
// ============================================================================
// A write word and a read word each give one result word through an output
// register, the read word by way of a wait state. A start word runs whole
// passes until one clears nothing; each subpass scans the interior twice,
// once for the neighbor reads on the single image read port that mark each
// interior pixel, and once for the mark and clear sweep.
`default_nettype none

module binary_image_thinning
    import bthin_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [8:0] cfg_wdata,
    bthin_req_if.sink       req,
    bthin_rsp_if.source     rsp
);

    bthin_cmd_t cmd;
    bthin_sts_t sts;

    bthin_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_ready    (req.ready),
        .out_ready   (rsp.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    bthin_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .req_type   (req.req_type),
        .row        (req.row),
        .col        (req.col),
        .pixel_in   (req.pixel_in),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .pixel_out  (rsp.pixel_out),
        .pass_count (rsp.pass_count),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

`default_nettype wire

>>> sv/bthin_checker.sv
// ============================================================================
// bthin_checker
// Port-level checks of the binary image thinning block.
// ============================================================================
`default_nettype none

module bthin_checker
    import bthin_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  pixel_out,
    input wire logic [15:0] pass_count
);

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!out_valid || out_ready))
        else $error("input taken while a result word is stuck");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pixel_out)))
        else $error("result word dropped or changed while stalled");

    a_pixel_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_out == PIX_FG || pixel_out == PIX_BG))
        else $error("pixel out is neither background nor foreground");

    a_pass_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pass_count <= PASS_LIMIT))
        else $error("pass count beyond its limit");

endmodule

bind binary_image_thinning bthin_checker u_bthin_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .pixel_out  (rsp.pixel_out),
    .pass_count (rsp.pass_count)
);

`default_nettype wire
